// File: src/awc_pkg.sv
package awc_pkg;

    // Fixed-point format of the mix weight.
    localparam int WEIGHT_FRAC_BITS = 12;
    localparam int MIX_ONE          = 1 << WEIGHT_FRAC_BITS;

    // Width of the mix_weight register, fixed by the register map.
    localparam int MIX_W = 13;

    // Saturated weight t and its complement, 0 .. MIX_ONE.
    localparam int WT_W = WEIGHT_FRAC_BITS + 1;

    // Weighted alpha a * w, and the combined alpha S, both at most 255 * MIX_ONE.
    localparam int PROD_W = WEIGHT_FRAC_BITS + 8;

    // Color times weighted alpha.
    localparam int CPROD_W = PROD_W + 8;

    // Divider remainder holds 2 * num + S, which stays below 512 * S.
    localparam int REM_W = WEIGHT_FRAC_BITS + 17;

    // Aligned divisor 2 * S shifted up by seven quotient places.
    localparam int DV_W = REM_W - 1;

    // Eight quotient bits per channel, two of them per divider stage.
    localparam int Q_W             = 8;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = Q_W / STEPS_PER_STAGE;

    // Color lanes of a packed pixel.
    localparam int LANES = 3;

    // Cycles from an accepted word to its result strobe.
    localparam int PIPE_LAT = 4 + DIV_STAGES;

    // Nearly transparent threshold: 50 * S below 255 * MIX_ONE.
    localparam int THRESH_NUM = 255 * MIX_ONE;
    localparam int THRESH_W   = PROD_W + 6;

    // Control word that travels down the pipeline with the data.
    typedef struct packed {
        logic           valid;
        logic           clear;
        logic [7:0]     alpha;
    } t_ctl;

    // One color lane of the divider: partial remainder and quotient so far.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } t_lane;

endpackage

// File: src/awc_div_stage.sv
module awc_div_stage
    import awc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic [DV_W-1:0]         i_dv,
    input  t_lane [LANES-1:0]       i_lane,
    output t_ctl                    o_ctl,
    output logic [DV_W-1:0]         o_dv,
    output t_lane [LANES-1:0]       o_lane
);

    t_ctl                r_ctl;
    logic [DV_W-1:0]     r_dv;
    t_lane [LANES-1:0]   r_lane;
    t_lane [LANES-1:0]   n_lane;

    // Two restoring division steps per lane against a fixed aligned divisor.
    // The remainder doubles after each step instead of shifting the divisor.
    always_comb begin
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic [REM_W-1:0] dv_ext;
        dv_ext = REM_W'(i_dv);
        for (int l = 0; l < LANES; l++) begin
            rem = i_lane[l].rem;
            q   = i_lane[l].q;
            for (int s = 0; s < STEPS_PER_STAGE; s++) begin
                if (rem >= dv_ext) begin
                    rem = rem - dv_ext;
                    q   = {q[Q_W-2:0], 1'b1};
                end else begin
                    q   = {q[Q_W-2:0], 1'b0};
                end
                rem = {rem[REM_W-2:0], 1'b0};
            end
            n_lane[l].rem = rem;
            n_lane[l].q   = q;
        end
    end

    // The valid bit is control state and is cleared by reset; the payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.clear <= i_ctl.clear;
        r_ctl.alpha <= i_ctl.alpha;
        r_dv        <= i_dv;
        r_lane      <= n_lane;
    end

    assign o_ctl  = r_ctl;
    assign o_dv   = r_dv;
    assign o_lane = r_lane;

`ifndef SYNTHESIS
    // After each stage the halved remainder of every lane is below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.valid && !r_ctl.clear) |->
            ((r_lane[0].rem >> 1) < REM_W'(r_dv)) &&
            ((r_lane[1].rem >> 1) < REM_W'(r_dv)) &&
            ((r_lane[2].rem >> 1) < REM_W'(r_dv)))
        else $error("divider remainder out of range");
`endif

endmodule

// File: src/alpha_weighted_crossfade.sv
// Alpha-weighted crossfade of two ARGB8888 pixels.
//
// Input channel: a word of two pixels (outgoing and incoming) is taken at a
// rising edge where start is high and busy is low. Busy is always low, so one
// word may be offered in every cycle and each word is independent.
// Configuration channel: the mix weight t (unsigned, 4096 means fully
// incoming) is written when i_cfg_valid and o_cfg_ready are both high. Ready
// is always high. Values above one are treated as one.
// Output channel: each result is on o_blended_pixel for one cycle, marked by
// o_valid, once its word has passed through the whole pipeline. Results come
// out in order, one per word, at up to one per cycle.
// Throughput is one word per cycle; the pipeline holds three arithmetic
// stages (weights, products, dividend), four divider stages of two
// quotient bits each, and the output register.
// The receiver cannot stall; the pipeline never holds a result back.
// Reset clears the weight to zero and drops every word in flight.
module alpha_weighted_crossfade
    import awc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [31:0]         i_outgoing_pixel,
    input  logic [31:0]         i_incoming_pixel,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [MIX_W-1:0]    i_cfg_data,
    output logic                o_valid,
    output logic [31:0]         o_blended_pixel
);

    logic [MIX_W-1:0]     r_mix_weight;

    // Stage 1: weighted alphas and color bytes.
    logic                 r1_valid;
    logic [PROD_W-1:0]    r1_wo;
    logic [PROD_W-1:0]    r1_wi;
    logic [23:0]          r1_co;
    logic [23:0]          r1_ci;
    logic [WT_W-1:0]      n_t;
    logic [PROD_W-1:0]    n_wo;
    logic [PROD_W-1:0]    n_wi;

    // Stage 2: color products, combined alpha, transparency and output alpha.
    logic                     r2_valid;
    logic [CPROD_W-1:0]       r2_po [LANES];
    logic [CPROD_W-1:0]       r2_pi [LANES];
    logic [PROD_W-1:0]        r2_s;
    logic                     r2_clear;
    logic [7:0]               r2_alpha;
    logic [PROD_W-1:0]        n_s;
    logic [THRESH_W-1:0]      n_s50;
    logic [PROD_W:0]          n_round;

    // Stage 3: dividend and aligned divisor.
    t_ctl                     r3_ctl;
    logic [DV_W-1:0]          r3_dv;
    t_lane [LANES-1:0]        r3_lane;
    t_lane [LANES-1:0]        n3_lane;

    // Divider chain.
    t_ctl                     d_ctl  [DIV_STAGES+1];
    logic [DV_W-1:0]          d_dv   [DIV_STAGES+1];
    t_lane [LANES-1:0]        d_lane [DIV_STAGES+1];

    // Output register.
    logic                     r_valid;
    logic [31:0]              r_blended;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Mix weight register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_weight <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mix_weight <= i_cfg_data;
        end
    end

    // Saturate the weight at one and weight both alphas.
    always_comb begin
        if (32'(r_mix_weight) > 32'(MIX_ONE)) begin
            n_t = WT_W'(MIX_ONE);
        end else begin
            n_t = WT_W'(r_mix_weight);
        end
        n_wo = PROD_W'(i_outgoing_pixel[31:24] * (WT_W'(MIX_ONE) - n_t));
        n_wi = PROD_W'(i_incoming_pixel[31:24] * n_t);
    end

    // Valid bits of the arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid     <= 1'b0;
            r2_valid     <= 1'b0;
        end else begin
            r1_valid     <= start && !busy;
            r2_valid     <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_wo <= n_wo;
        r1_wi <= n_wi;
        r1_co <= i_outgoing_pixel[23:0];
        r1_ci <= i_incoming_pixel[23:0];
    end

    // Combined alpha, the transparency test and the rounded output alpha.
    always_comb begin
        n_s     = r1_wo + r1_wi;
        n_s50   = THRESH_W'(n_s) * THRESH_W'(50);
        n_round = (PROD_W+1)'(n_s) + (PROD_W+1)'(MIX_ONE / 2);
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r2_po[l] <= CPROD_W'(r1_co[8*l +: 8] * r1_wo);
            r2_pi[l] <= CPROD_W'(r1_ci[8*l +: 8] * r1_wi);
        end
        r2_s     <= n_s;
        r2_clear <= n_s50 < THRESH_W'(THRESH_NUM);
        r2_alpha <= n_round[WEIGHT_FRAC_BITS +: 8];
    end

    // Dividend 2 * num + S for each lane; the quotient starts empty.
    always_comb begin
        logic [CPROD_W:0] num;
        for (int l = 0; l < LANES; l++) begin
            num             = (CPROD_W+1)'(r2_po[l]) + (CPROD_W+1)'(r2_pi[l]);
            n3_lane[l].rem  = REM_W'({num, 1'b0} + (CPROD_W+2)'(r2_s));
            n3_lane[l].q    = '0;
        end
    end

    // Stage 3 register; only its valid bit is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl.valid <= 1'b0;
        end else begin
            r3_ctl.valid <= r2_valid;
        end
        r3_ctl.clear <= r2_clear;
        r3_ctl.alpha <= r2_alpha;
        r3_dv        <= DV_W'({r2_s, 1'b0}) << (Q_W - 1);
        r3_lane      <= n3_lane;
    end

    assign d_ctl[0]  = r3_ctl;
    assign d_dv[0]   = r3_dv;
    assign d_lane[0] = r3_lane;

    // Pipelined divider, two quotient bits per stage.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        awc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (d_ctl[k]),
            .i_dv    (d_dv[k]),
            .i_lane  (d_lane[k]),
            .o_ctl   (d_ctl[k+1]),
            .o_dv    (d_dv[k+1]),
            .o_lane  (d_lane[k+1])
        );
    end

    // Output register: pack the pixel or force transparent black.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_ctl[DIV_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_ctl[DIV_STAGES].clear) begin
            r_blended <= '0;
        end else begin
            r_blended <= {d_ctl[DIV_STAGES].alpha,
                          d_lane[DIV_STAGES][2].q,
                          d_lane[DIV_STAGES][1].q,
                          d_lane[DIV_STAGES][0].q};
        end
    end

    assign o_valid         = r_valid;
    assign o_blended_pixel = r_blended;

`ifndef SYNTHESIS
    // Every result strobe belongs to an accepted input word.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result strobe without a matching input word");

    // Every accepted word gives a result strobe.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT (o_valid || !i_rst_n))
        else $error("input word lost in the pipeline");

    // A pixel that is not transparent black carries a nonzero alpha.
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_blended_pixel != 32'd0)) |-> (o_blended_pixel[31:24] != 8'd0))
        else $error("opaque color with zero alpha");
`endif

endmodule
